@@ rtl/olia_pkg.sv @@
// Package for the ordered list insert core.
// Holds the result status codes, controller states and the cell command.
// No dependencies.
package olia_pkg;

    localparam int CMD_W = 7;

    typedef enum logic [1:0] {
        ST_INSERTED   = 2'd0,
        ST_FULL       = 2'd1,
        ST_DUMP_ENTRY = 2'd2,
        ST_DUMP_EMPTY = 2'd3
    } t_status;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DUMP   = 1'b1
    } t_opcode;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } t_state;

    typedef struct packed {
        logic             ins;
        logic             rot;
        logic [CMD_W-1:0] pos;
        logic [CMD_W-1:0] cnt;
        logic [CMD_W-1:0] last;
    } t_cell_cmd;

endpackage

@@ rtl/olia_cell.sv @@
// One list cell: holds one entry and loads it from the new value, a neighbor or the wrap input.
// Depends on olia_pkg for the broadcast cell command.
module olia_cell #(
    parameter int IDX = 0
) (
    input  logic                  i_clk,
    input  olia_pkg::t_cell_cmd   i_cmd,
    input  logic signed [31:0]    i_new,
    input  logic signed [31:0]    i_prev,
    input  logic signed [31:0]    i_next,
    input  logic signed [31:0]    i_wrap,
    output logic signed [31:0]    o_value
);

    localparam logic [olia_pkg::CMD_W-1:0] MY_IDX = olia_pkg::CMD_W'(IDX);

    logic signed [31:0] r_value;
    logic signed [31:0] n_value;

    always_comb begin
        n_value = r_value;
        if (i_cmd.ins) begin
            if (MY_IDX == i_cmd.pos) begin
                n_value = i_new;
            end else if (MY_IDX > i_cmd.pos && MY_IDX <= i_cmd.cnt) begin
                n_value = i_prev;
            end
        end else if (i_cmd.rot) begin
            if (MY_IDX < i_cmd.last) begin
                n_value = i_next;
            end else if (MY_IDX == i_cmd.last) begin
                n_value = i_wrap;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

@@ rtl/ordered_list_insert_at_position_core.sv @@
// Top level of the ordered list insert core: controller, count and row of cells.
// Depends on olia_pkg and olia_cell.
//
// Usage: drive i_opcode, i_item_value and i_position with start high; the
// beat is taken at a rising edge where busy is low. Results leave on the
// o_ ports for one cycle each, marked by o_strobe; the receiver cannot stall.
// An insert (opcode 0) shifts all cells after the clamped position back by
// one at the accept edge and gives one result the next cycle, so inserts run one
// per cycle while busy is low. A full list drops the insert with status full.
// A dump (opcode 1) rotates the row of cells toward cell 0 once per cycle,
// emitting cell 0 each cycle: N entries give N results in list order, with
// busy high during the dump; after N rotations the list is back in place.
// An empty list gives one empty result the next cycle.
// An insert or an empty dump is answered straight from the result registers;
// a dump passes S_DUMP first and takes no new beat while busy is high.
// Reset (i_rst_n low, synchronous) empties the list and clears o_strobe.
module ordered_list_insert_at_position_core #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_opcode,
    input  logic signed [31:0] i_item_value,
    input  logic [7:0]         i_position,
    output logic               o_strobe,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_out_value,
    output logic [3:0]         o_entry_index,
    output logic [4:0]         o_list_length,
    output logic               o_last_result
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    olia_pkg::t_state    r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [IW-1:0]       r_idx, n_idx;
    logic                r_strobe, n_strobe;
    logic [1:0]          r_status, n_status;
    logic signed [31:0]  r_out_value, n_out_value;
    logic [3:0]          r_entry_index, n_entry_index;
    logic [4:0]          r_list_length, n_list_length;
    logic                r_last_result, n_last_result;

    olia_pkg::t_cell_cmd cmd;
    logic                accept;
    logic                full;
    logic [CW-1:0]       pos_clamp;
    logic [CW-1:0]       last_pos;
    logic signed [31:0]  cell_val [DEPTH];

    assign accept    = start && (r_state == olia_pkg::S_IDLE);
    assign full      = (r_count == FULL_CNT);
    assign pos_clamp = (i_position > 8'(r_count)) ? r_count : CW'(i_position);
    assign last_pos  = r_count - CW'(1);

    always_comb begin
        cmd.ins  = accept && (i_opcode == olia_pkg::OP_INSERT) && !full;
        cmd.rot  = (r_state == olia_pkg::S_DUMP);
        cmd.pos  = olia_pkg::CMD_W'(pos_clamp);
        cmd.cnt  = olia_pkg::CMD_W'(r_count);
        cmd.last = olia_pkg::CMD_W'(last_pos);
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [31:0] prev_v;
        logic signed [31:0] next_v;
        if (g == 0) begin : g_first
            assign prev_v = '0;
        end else begin : g_mid_p
            assign prev_v = cell_val[g-1];
        end
        if (g == DEPTH - 1) begin : g_end
            assign next_v = '0;
        end else begin : g_mid_n
            assign next_v = cell_val[g+1];
        end
        olia_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_new   (i_item_value),
            .i_prev  (prev_v),
            .i_next  (next_v),
            .i_wrap  (cell_val[0]),
            .o_value (cell_val[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= olia_pkg::S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status      <= n_status;
        r_out_value   <= n_out_value;
        r_entry_index <= n_entry_index;
        r_list_length <= n_list_length;
        r_last_result <= n_last_result;
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_idx         = r_idx;
        n_strobe      = 1'b0;
        n_status      = r_status;
        n_out_value   = r_out_value;
        n_entry_index = r_entry_index;
        n_list_length = r_list_length;
        n_last_result = r_last_result;
        case (r_state)
            olia_pkg::S_IDLE: begin
                if (start) begin
                    n_strobe      = 1'b1;
                    n_out_value   = '0;
                    n_last_result = 1'b1;
                    if (i_opcode == olia_pkg::OP_INSERT) begin
                        if (full) begin
                            n_status      = olia_pkg::ST_FULL;
                            n_entry_index = '0;
                            n_list_length = 5'(r_count);
                        end else begin
                            n_count       = r_count + CW'(1);
                            n_status      = olia_pkg::ST_INSERTED;
                            n_entry_index = 4'(pos_clamp);
                            n_list_length = 5'(r_count + CW'(1));
                        end
                    end else if (r_count == '0) begin
                        n_status      = olia_pkg::ST_DUMP_EMPTY;
                        n_entry_index = '0;
                        n_list_length = '0;
                    end else begin
                        n_strobe = 1'b0;
                        n_idx    = '0;
                        n_state  = olia_pkg::S_DUMP;
                    end
                end
            end
            olia_pkg::S_DUMP: begin
                n_strobe      = 1'b1;
                n_status      = olia_pkg::ST_DUMP_ENTRY;
                n_out_value   = cell_val[0];
                n_entry_index = 4'(r_idx);
                n_list_length = 5'(r_count);
                n_last_result = (CW'(r_idx) == last_pos);
                n_idx         = r_idx + IW'(1);
                if (CW'(r_idx) == last_pos) begin
                    n_state = olia_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = olia_pkg::S_IDLE;
            end
        endcase
    end

    assign busy          = (r_state == olia_pkg::S_DUMP);
    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_out_value   = r_out_value;
    assign o_entry_index = r_entry_index;
    assign o_list_length = r_list_length;
    assign o_last_result = r_last_result;

    a_busy_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> r_count != '0)
        else $error("dump running on an empty list");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above depth");

    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_opcode == olia_pkg::OP_INSERT) |=> o_strobe)
        else $error("insert beat gave no result");

    a_length_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_list_length == 5'(r_count))
        else $error("reported length differs from count");

    a_dump_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_strobe && o_last_result))
        else $error("dump ended without a last beat");

endmodule
